### hw/rtl/dda_grid_ray_traversal_core_assert.svh
// Assertion macros used by the file that checks its own behaviour.
`ifndef DDA_GRID_RAY_TRAVERSAL_CORE_ASSERT_SVH
`define DDA_GRID_RAY_TRAVERSAL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DGRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgrt assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define DGRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgrt assertion failed (next cycle)");

`endif

### hw/rtl/dgrt_pkg.sv
`default_nettype none
package dgrt_pkg;

    localparam int MAP_W   = 64;
    localparam int MAP_H   = 64;
    localparam int COL_W   = $clog2(MAP_W);
    localparam int ROW_W   = $clog2(MAP_H);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int CELLS   = MAP_W * MAP_H;
    localparam int LEN_W   = 7;
    localparam int POS_W   = 8;
    localparam int DIST_W  = 32;
    localparam int CMD_W   = 2;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [CMD_W-1:0] {
        CMD_WALL = 2'd0,
        CMD_LEN  = 2'd1,
        CMD_CAST = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_CHECK,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load_wall;
        logic load_len;
        logic start;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic stop;
    } t_dp_status;

endpackage
`default_nettype wire

### hw/rtl/dgrt_ctrl.sv
`default_nettype none
module dgrt_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic [dgrt_pkg::CMD_W-1:0]   i_s_tuser,
    input  wire logic                         i_m_tready,
    input  wire dgrt_pkg::t_dp_status         i_status,
    output logic                              o_s_tready,
    output logic                              o_m_tvalid,
    output dgrt_pkg::t_dp_cmd                 o_cmd
);

    dgrt_pkg::t_state r_state, n_state;
    logic             r_out_valid;
    logic             accept;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_m_tready;
    assign accept    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dgrt_pkg::ST_IDLE: begin
                if (accept && (i_s_tuser == dgrt_pkg::CMD_CAST)) begin
                    n_state = dgrt_pkg::ST_STEP;
                end
            end
            dgrt_pkg::ST_STEP: begin
                n_state = dgrt_pkg::ST_CHECK;
            end
            dgrt_pkg::ST_CHECK: begin
                if (i_status.stop) begin
                    n_state = slot_free ? dgrt_pkg::ST_IDLE : dgrt_pkg::ST_HOLD;
                end else begin
                    n_state = dgrt_pkg::ST_STEP;
                end
            end
            dgrt_pkg::ST_HOLD: begin
                if (slot_free) begin
                    n_state = dgrt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dgrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            dgrt_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (accept) begin
                    case (i_s_tuser)
                        dgrt_pkg::CMD_WALL: o_cmd.load_wall = 1'b1;
                        dgrt_pkg::CMD_LEN:  o_cmd.load_len  = 1'b1;
                        dgrt_pkg::CMD_CAST: o_cmd.start     = 1'b1;
                        default:            o_cmd           = '0;
                    endcase
                end
            end
            dgrt_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
            end
            dgrt_pkg::ST_CHECK: begin
                o_cmd.emit = i_status.stop && slot_free;
            end
            dgrt_pkg::ST_HOLD: begin
                o_cmd.emit = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dgrt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

### hw/rtl/dgrt_datapath.sv
`default_nettype none
module dgrt_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dgrt_pkg::t_dp_cmd                 i_cmd,
    input  wire logic                              i_cfg_valid,
    input  wire logic [dgrt_pkg::LEN_W-1:0]        i_cfg_data,
    input  wire logic [dgrt_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output dgrt_pkg::t_dp_status                   o_status,
    output logic [dgrt_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic                                   o_m_tuser
);

    localparam int LW = dgrt_pkg::LEN_W;
    localparam int PW = dgrt_pkg::POS_W;
    localparam int DW = dgrt_pkg::DIST_W;
    localparam int CW = dgrt_pkg::COL_W;
    localparam int RW = dgrt_pkg::ROW_W;

    // Input beat fields.
    logic [RW-1:0] in_row;
    logic [CW-1:0] in_col;
    logic          in_wall;
    logic [LW-1:0] in_len;
    logic [DW-1:0] in_sdx, in_sdy, in_dx, in_dy;
    logic          in_sxn, in_syn;

    assign in_row  = i_s_tdata[5:0];
    assign in_col  = i_s_tdata[11:6];
    assign in_wall = i_s_tdata[12];
    assign in_len  = i_s_tdata[19:13];
    assign in_sdx  = i_s_tdata[51:20];
    assign in_sdy  = i_s_tdata[83:52];
    assign in_dx   = i_s_tdata[115:84];
    assign in_dy   = i_s_tdata[147:116];
    assign in_sxn  = i_s_tdata[148];
    assign in_syn  = i_s_tdata[149];

    logic                  r_wall_mem [dgrt_pkg::CELLS];
    logic [LW-1:0]         r_len_mem  [dgrt_pkg::MAP_H];
    logic [dgrt_pkg::MAP_H-1:0] r_len_vld;
    logic [LW-1:0]         r_row_count;

    logic [PW-1:0] r_col, r_row, n_col, n_row;
    logic [DW-1:0] r_dist_x, r_dist_y, n_dist_x, n_dist_y;
    logic [DW-1:0] r_delta_x, r_delta_y;
    logic          r_sxn, r_syn;
    logic          r_side, n_side;
    logic          r_wall_q;
    logic [LW-1:0] r_len_q;
    logic          r_len_vld_q;

    logic [DW:0]   sum_x, sum_y;
    logic [dgrt_pkg::ADDR_W-1:0] rd_addr;

    logic          r_out_kind;
    logic [PW-1:0] r_out_col, r_out_row;
    logic          r_out_side;
    logic [DW-1:0] r_out_dx, r_out_dy;

    assign sum_x = {1'b0, r_dist_x} + {1'b0, r_delta_x};
    assign sum_y = {1'b0, r_dist_y} + {1'b0, r_delta_y};

    // Row axis wins on equal distances.
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_dist_x = r_dist_x;
        n_dist_y = r_dist_y;
        if (r_dist_x < r_dist_y) begin
            n_dist_x = sum_x[DW] ? '1 : sum_x[DW-1:0];
            n_col    = r_sxn ? (r_col - PW'(1)) : (r_col + PW'(1));
            n_side   = 1'b0;
        end else begin
            n_dist_y = sum_y[DW] ? '1 : sum_y[DW-1:0];
            n_row    = r_syn ? (r_row - PW'(1)) : (r_row + PW'(1));
            n_side   = 1'b1;
        end
    end

    assign rd_addr = {n_row[RW-1:0], n_col[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wall) begin
            r_wall_mem[{in_row, in_col}] <= in_wall;
        end
        if (i_cmd.step) begin
            r_wall_q <= r_wall_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_len) begin
            r_len_mem[in_row] <= in_len;
        end
        if (i_cmd.step) begin
            r_len_q <= r_len_mem[n_row[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld   <= '0;
            r_row_count <= '0;
        end else begin
            if (i_cmd.load_len) begin
                r_len_vld[in_row] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_row_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_col     <= PW'(in_col);
            r_row     <= PW'(in_row);
            r_dist_x  <= in_sdx;
            r_dist_y  <= in_sdy;
            r_delta_x <= in_dx;
            r_delta_y <= in_dy;
            r_sxn     <= in_sxn;
            r_syn     <= in_syn;
            r_side    <= 1'b0;
        end else if (i_cmd.step) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_dist_x    <= n_dist_x;
            r_dist_y    <= n_dist_y;
            r_side      <= n_side;
            r_len_vld_q <= r_len_vld[n_row[RW-1:0]];
        end
    end

    // Bounds test on the cell just stepped into; a negative coordinate has bit 7 set.
    logic [LW-1:0] rows_in_use, len_eff;
    logic          oob, hit;

    always_comb begin
        rows_in_use = (r_row_count > LW'(dgrt_pkg::MAP_H)) ? LW'(dgrt_pkg::MAP_H)
                                                           : r_row_count;
        if (!r_len_vld_q) begin
            len_eff = '0;
        end else begin
            len_eff = (r_len_q > LW'(dgrt_pkg::MAP_W)) ? LW'(dgrt_pkg::MAP_W) : r_len_q;
        end
        oob = r_row[PW-1] || r_col[PW-1] ||
              (r_row[LW-1:0] >= rows_in_use) ||
              (r_col[LW-1:0] >= len_eff);
        hit = !oob && r_wall_q;
    end

    assign o_status.stop = oob || hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= oob;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_side <= r_side;
            r_out_dx   <= r_dist_x;
            r_out_dy   <= r_dist_y;
        end
    end

    assign o_m_tuser = r_out_kind;
    assign o_m_tdata = {7'd0, r_out_dy, r_out_dx, r_out_side, r_out_row, r_out_col};

endmodule
`default_nettype wire

### hw/rtl/dda_grid_ray_traversal_core.sv
// Grid ray walker. Load beats (tuser 0 wall cell, tuser 1 row length) leave the input open and
// give no result. A cast beat (tuser 2) walks the map one grid step at a time; each step first
// advances the axis with the smaller side distance and registers a read of the wall map and row
// length memories at the new cell, then tests that cell. A cast keeps the input closed until its
// result enters the output register, in the cycle after its last test if that register is free;
// the walk takes at most about map width plus map height steps. The result waits
// in an output register, so loads are taken while it is pending; a further cast stalls at its
// end only if the previous result has still not been taken. row_count may be written at any
// idle time; the configuration channel is always ready.
`default_nettype none
`include "dda_grid_ray_traversal_core_assert.svh"
module dda_grid_ray_traversal_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dgrt_pkg::LEN_W-1:0]         i_cfg_data,   // row_count
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // row, col, wall, row_length, side_dist_x, side_dist_y, delta_x, delta_y,
    // step_x_neg, step_y_neg, zero padding
    input  wire logic [dgrt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  wire logic [dgrt_pkg::CMD_W-1:0]         i_s_tuser,    // cmd
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // end_col, end_row, side, final_side_dist_x, final_side_dist_y, zero padding
    output logic [dgrt_pkg::OUT_DATA_W-1:0]         o_m_tdata,
    output logic                                    o_m_tuser     // hit_kind
);

    dgrt_pkg::t_dp_cmd    dp_cmd;
    dgrt_pkg::t_dp_status dp_status;
    logic                 cast_beat;
    logic                 load_beat;
    logic                 wall_result;

    assign o_cfg_ready = 1'b1;

    dgrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_status   (dp_status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (dp_cmd)
    );

    dgrt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_status    (dp_status),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    assign cast_beat   = i_s_tvalid && o_s_tready && (i_s_tuser == dgrt_pkg::CMD_CAST);
    assign load_beat   = i_s_tvalid && o_s_tready && (i_s_tuser != dgrt_pkg::CMD_CAST);
    assign wall_result = o_m_tvalid && !o_m_tuser;

    // A cast closes the input for at least its first step.
    `DGRT_ASSERT_NEXT(a_cast_closes_input, i_clk, i_rst_n, cast_beat, !o_s_tready)

    // A wall hit always lies inside the map, so neither coordinate is negative.
    `DGRT_ASSERT_NOW(a_hit_inside_map, i_clk, i_rst_n, wall_result, !o_m_tdata[7] && !o_m_tdata[15])

    // Load beats never create a result.
    `DGRT_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, load_beat && !o_m_tvalid, !o_m_tvalid)

endmodule
`default_nettype wire

### bench/tb_dda_grid_ray_traversal_core.sv
`default_nettype none

module tb_dda_grid_ray_traversal_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W  = dgrt_pkg::CMD_W;
    localparam int ROW_W  = dgrt_pkg::ROW_W;
    localparam int COL_W  = dgrt_pkg::COL_W;
    localparam int LEN_W  = dgrt_pkg::LEN_W;
    localparam int POS_W  = dgrt_pkg::POS_W;
    localparam int DIST_W = dgrt_pkg::DIST_W;
    localparam int MAP_W  = dgrt_pkg::MAP_W;
    localparam int MAP_H  = dgrt_pkg::MAP_H;
    localparam int CELLS  = dgrt_pkg::CELLS;
    localparam int IN_W   = dgrt_pkg::IN_DATA_W;
    localparam int OUT_W  = dgrt_pkg::OUT_DATA_W;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic HIT_WALL = 1'b0;
    localparam logic HIT_OUT  = 1'b1;
    localparam logic SIDE_COL = 1'b0;
    localparam logic SIDE_ROW = 1'b1;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BEATS  = 340;
    localparam int QUIET_BEATS   = 50;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              wall;
        logic [LEN_W-1:0]  row_length;
        logic [DIST_W-1:0] sdx;
        logic [DIST_W-1:0] sdy;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        logic              sxn;
        logic              syn;
    } t_ray_beat;

    typedef struct packed {
        logic              hit_kind;
        logic [POS_W-1:0]  end_col;
        logic [POS_W-1:0]  end_row;
        logic              side;
        logic [DIST_W-1:0] fdx;
        logic [DIST_W-1:0] fdy;
    } t_ray_end;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]  s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    // Shadow copy of the block's map, row lengths and row count.
    logic             grid_wall [CELLS];
    bit               wall_set  [CELLS];
    logic [LEN_W-1:0] row_len   [MAP_H];
    logic [LEN_W-1:0] rows_cfg;

    t_ray_end pending_hits[$];

    bit offering = 1'b0;
    int src_gap_pct = 0;
    int sink_gap_pct = 0;
    int hold_req = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int beats_sent = 0;
    int casts_sent = 0;
    int wall_hits = 0;
    int left_map = 0;
    int cfg_writes = 0;

    dda_grid_ray_traversal_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [DIST_W-1:0] dist_add(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? '1 : s[DIST_W-1:0];
    endfunction

    // Walks the shadow map. Returns 0 if the walk would read a cell never written.
    function automatic bit trace_ray(input t_ray_beat b, output t_ray_end r);
        int c;
        int rw;
        int lim_rows;
        int lim_cols;
        logic [DIST_W-1:0] ax;
        logic [DIST_W-1:0] ay;
        bit done;
        bit safe;
        c = int'(b.col);
        rw = int'(b.row);
        ax = b.sdx;
        ay = b.sdy;
        done = 1'b0;
        safe = 1'b1;
        r = '0;
        lim_rows = (int'(rows_cfg) > MAP_H) ? MAP_H : int'(rows_cfg);
        while (!done) begin
            if (ax < ay) begin
                ax = dist_add(ax, b.dx);
                c = b.sxn ? c - 1 : c + 1;
                r.side = SIDE_COL;
            end else begin
                ay = dist_add(ay, b.dy);
                rw = b.syn ? rw - 1 : rw + 1;
                r.side = SIDE_ROW;
            end
            if (c < 0 || rw < 0 || rw >= lim_rows) begin
                r.hit_kind = HIT_OUT;
                done = 1'b1;
            end else begin
                lim_cols = (int'(row_len[rw]) > MAP_W) ? MAP_W : int'(row_len[rw]);
                if (c >= lim_cols) begin
                    r.hit_kind = HIT_OUT;
                    done = 1'b1;
                end else if (!wall_set[rw * MAP_W + c]) begin
                    safe = 1'b0;
                    done = 1'b1;
                end else if (grid_wall[rw * MAP_W + c] == 1'b1) begin
                    r.hit_kind = HIT_WALL;
                    done = 1'b1;
                end
            end
        end
        r.end_col = c[POS_W-1:0];
        r.end_row = rw[POS_W-1:0];
        r.fdx = ax;
        r.fdy = ay;
        return safe;
    endfunction

    function automatic void apply_beat(input t_ray_beat b);
        t_ray_end r;
        case (b.cmd)
            dgrt_pkg::CMD_WALL: begin
                grid_wall[b.row * MAP_W + b.col] = b.wall;
                wall_set[b.row * MAP_W + b.col] = 1'b1;
            end
            dgrt_pkg::CMD_LEN: row_len[b.row] = b.row_length;
            dgrt_pkg::CMD_CAST: begin
                void'(trace_ray(b, r));
                pending_hits.push_back(r);
                casts_sent++;
                if (r.hit_kind == HIT_WALL) wall_hits++;
                else left_map++;
            end
            default: ;
        endcase
    endfunction

    function automatic t_ray_beat rand_beat(input logic [CMD_W-1:0] cmd);
        t_ray_beat b;
        b.cmd = cmd;
        b.row = ROW_W'($urandom);
        b.col = COL_W'($urandom);
        b.wall = 1'($urandom);
        b.row_length = LEN_W'($urandom);
        b.sdx = $urandom;
        b.sdy = $urandom;
        b.dx = $urandom;
        b.dy = $urandom;
        b.sxn = 1'($urandom);
        b.syn = 1'($urandom);
        return b;
    endfunction

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
            default: return $urandom_range(0, 32'h0008_0000);
        endcase
    endfunction

    // A cast that never reaches an unwritten cell; falls back to a corner start
    // whose first step always leaves the map.
    function automatic t_ray_beat safe_cast(input int h);
        t_ray_beat b;
        t_ray_end r;
        for (int tries = 0; tries < 20; tries++) begin
            b = rand_beat(dgrt_pkg::CMD_CAST);
            if ($urandom_range(0, 7) != 0) begin
                b.row = ROW_W'($urandom_range(0, h - 1));
                b.col = COL_W'($urandom_range(0, 7));
            end
            b.sdx = pick_dist();
            b.sdy = pick_dist();
            b.dx = pick_dist();
            b.dy = pick_dist();
            if (trace_ray(b, r)) return b;
        end
        b.row = '1;
        b.col = '1;
        b.sxn = 1'b0;
        b.syn = 1'b0;
        return b;
    endfunction

    task automatic send_beat(input t_ray_beat b);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            if (offering) begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        offering = 1'b1;
        s_tuser <= b.cmd;
        s_tdata <= {2'b00, b.syn, b.sxn, b.dy, b.dx, b.sdy, b.sdx,
                    b.row_length, b.wall, b.col, b.row};
        do @(posedge clk); while (!s_tready);
        apply_beat(b);
        beats_sent++;
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int row, input int col,
                            input logic wall, input int len);
        t_ray_beat b;
        b = rand_beat(cmd);
        b.row = ROW_W'(row);
        b.col = COL_W'(col);
        b.wall = wall;
        b.row_length = LEN_W'(len);
        send_beat(b);
    endtask

    task automatic send_cast(input int row, input int col, input logic [DIST_W-1:0] sdx,
                             input logic [DIST_W-1:0] sdy, input logic [DIST_W-1:0] dx,
                             input logic [DIST_W-1:0] dy, input logic sxn, input logic syn);
        t_ray_beat b;
        b = rand_beat(dgrt_pkg::CMD_CAST);
        b.row = ROW_W'(row);
        b.col = COL_W'(col);
        b.sdx = sdx;
        b.sdy = sdy;
        b.dx = dx;
        b.dy = dy;
        b.sxn = sxn;
        b.syn = syn;
        send_beat(b);
    endtask

    // Stops offering and waits until every cast has reported, then lets a
    // trailing load finish.
    task automatic wait_drained();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_row_count(input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= LEN_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rows_cfg = LEN_W'(value);
        cfg_writes++;
    endtask

    task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_ray_end due;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                $error("result beat with no cast outstanding: tuser %0h tdata %0h",
                       m_tuser, m_tdata);
                fail_count++;
            end else begin
                due = pending_hits.pop_front();
                check_field("hit_kind", DIST_W'(due.hit_kind), DIST_W'(m_tuser));
                check_field("end_col", DIST_W'(due.end_col), DIST_W'(m_tdata[7:0]));
                check_field("end_row", DIST_W'(due.end_row), DIST_W'(m_tdata[15:8]));
                check_field("side", DIST_W'(due.side), DIST_W'(m_tdata[16]));
                check_field("final_side_dist_x", due.fdx, m_tdata[48:17]);
                check_field("final_side_dist_y", due.fdy, m_tdata[80:49]);
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off when a test asks for one.
    initial begin
        forever begin
            if (hold_req != 0) begin
                m_tready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end else if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("dda_grid_ray_traversal_core verification failed");
        $finish;
    end

    // Empty map after reset: every first step leaves the map.
    task automatic test_empty_map();
        send_cast(0, 0, '0, '0, '0, '0, 1'b0, 1'b0);
        send_cast(63, 63, '1, '1, '1, '1, 1'b1, 1'b1);
        send_cast(10, 20, '0, '1, '1, 32'h0001_0000, 1'b0, 1'b1);
        send_cmd(CMD_NONE, 63, 63, 1'b1, 127);
    endtask

    // Row count and row length above the map size are clamped.
    task automatic test_oversized_counts();
        set_row_count(127);
        send_cmd(dgrt_pkg::CMD_LEN, 0, 0, 1'b0, 127);
        send_cmd(dgrt_pkg::CMD_LEN, 63, 0, 1'b0, 64);
        send_cast(63, 10, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  1'b0, 1'b0);
        send_cast(0, 63, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                  1'b0, 1'b0);
        send_cast(0, 0, 32'hFFFF_0000, '1, 32'h0002_0000, '1, 1'b1, 1'b0);
        send_cast(0, 5, '1, 32'h0000_8000, '0, '1, 1'b0, 1'b1);
    endtask

    // A fully written two by four map with walls at row 0 col 3 and row 1 col 0.
    task automatic test_wall_hits();
        set_row_count(2);
        send_cmd(dgrt_pkg::CMD_LEN, 0, 0, 1'b0, 4);
        send_cmd(dgrt_pkg::CMD_LEN, 1, 0, 1'b0, 4);
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 4; c++) begin
                send_cmd(dgrt_pkg::CMD_WALL, r, c, (r == 0 && c == 3) || (r == 1 && c == 0), 0);
            end
        end
        send_cast(0, 0, '0, 32'h0008_0000, 32'h0001_0000, 32'h0010_0000, 1'b0, 1'b0);
        send_cast(0, 0, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000,
                  1'b0, 1'b0);
        send_cast(1, 1, '0, 32'h0000_0001, '0, 32'h0001_0000, 1'b0, 1'b0);
        send_cast(0, 1, 32'h0000_0001, '0, 32'h0003_0000, 32'h0001_8000, 1'b0, 1'b0);
    endtask

    // The sink holds off while casts keep coming, so the block backs up.
    task automatic test_output_stall();
        src_gap_pct = 0;
        hold_req = 400;
        for (int i = 0; i < 6; i++) begin
            send_beat(safe_cast(2));
            send_cmd(dgrt_pkg::CMD_WALL, $urandom_range(0, 1), $urandom_range(0, 3),
                     1'($urandom), 0);
        end
        wait_drained();
    endtask

    task automatic run_scene(input bit quiet);
        int h;
        int len;
        int rc;
        h = $urandom_range(1, 6);
        case ($urandom_range(0, 9))
            0: rc = 0;
            1: rc = 64;
            2: rc = 127;
            3: rc = $urandom_range(0, 127);
            default: rc = h;
        endcase
        set_row_count(rc);
        if (quiet) begin
            src_gap_pct = 0;
            sink_gap_pct = 0;
        end else begin
            src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            sink_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        end
        for (int r = 0; r < h; r++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            send_cmd(dgrt_pkg::CMD_LEN, r, 0, 1'b0, len);
            for (int c = 0; c < ((len > 8) ? 8 : len); c++) begin
                send_cmd(dgrt_pkg::CMD_WALL, r, c, $urandom_range(0, 3) == 0, 0);
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_beat(rand_beat(dgrt_pkg::CMD_WALL));
                        1: send_beat(rand_beat(dgrt_pkg::CMD_LEN));
                        default: send_beat(rand_beat(CMD_NONE));
                    endcase
                end
            end
        end
        repeat ($urandom_range(3, 10)) send_beat(safe_cast(h));
    endtask

    task automatic test_random_scenes(input int count, input bit quiet);
        int stop_at;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) run_scene(quiet);
    endtask

    initial begin
        rows_cfg = '0;
        foreach (row_len[i]) row_len[i] = '0;
        foreach (wall_set[i]) wall_set[i] = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_map();
        test_oversized_counts();
        test_wall_hits();
        test_output_stall();
        test_random_scenes(RANDOM_BEATS, 1'b0);
        test_random_scenes(QUIET_BEATS, 1'b1);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        $display("%0d beats sent, %0d casts (%0d wall hits, %0d left the map)",
                 beats_sent, casts_sent, wall_hits, left_map);
        $display("%0d row_count writes, from oversized values down to small random maps",
                 cfg_writes);
        if (fail_count == 0 && pending_hits.size() == 0) begin
            $display("dda_grid_ray_traversal_core verification clean");
        end else begin
            $display("dda_grid_ray_traversal_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/dgrt_pkg.sv
hw/rtl/dgrt_ctrl.sv
hw/rtl/dgrt_datapath.sv
hw/rtl/dda_grid_ray_traversal_core.sv
bench/tb_dda_grid_ray_traversal_core.sv
